>>> sv/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> sv/mm3sm_pkg.sv
`timescale 1ns / 1ps

package mm3sm_pkg;

    // Number of register stages from the input to the output register.
    localparam int NUM_STAGES = 16;

    localparam logic [63:0] MIX_C1    = 64'h87c37b91114253d5;
    localparam logic [63:0] MIX_C2    = 64'h4cf5ad432745937f;
    localparam logic [63:0] FIN_D1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FIN_D2    = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] LANE1_ADD = 64'h0000000052dce729;
    localparam logic [63:0] LANE2_ADD = 64'h0000000038495ab5;
    localparam logic [63:0] BLOCK_LEN = 64'd16;

    // Partial products of a 64 by 64 multiply kept modulo 2^64.
    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] cross_a;
        logic [31:0] cross_b;
    } pp_t;

    function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
        pp_t p;
        p.lo      = {32'h0, a[31:0]} * {32'h0, b[31:0]};
        p.cross_a = a[31:0] * b[63:32];
        p.cross_b = a[63:32] * b[31:0];
        return p;
    endfunction

    function automatic logic [63:0] pp_sum(input pp_t p);
        logic [31:0] cross_sum;
        cross_sum = p.cross_a + p.cross_b;
        return p.lo + {cross_sum, 32'h0};
    endfunction

    function automatic logic [63:0] rotl27(input logic [63:0] x);
        return {x[36:0], x[63:37]};
    endfunction

    function automatic logic [63:0] rotl31(input logic [63:0] x);
        return {x[32:0], x[63:33]};
    endfunction

    function automatic logic [63:0] rotl33(input logic [63:0] x);
        return {x[30:0], x[63:31]};
    endfunction

    function automatic logic [63:0] fold33(input logic [63:0] x);
        return x ^ {33'h0, x[63:33]};
    endfunction

endpackage

>>> sv/mm3sm_key_if.sv
`timescale 1ns / 1ps

interface mm3sm_key_if;
    logic        valid;
    logic        ready;
    logic [63:0] key_first;
    logic [63:0] key_second;
    logic [63:0] seed_word;

    modport source (output valid, output key_first, output key_second, output seed_word,
                    input ready);
    modport sink   (input valid, input key_first, input key_second, input seed_word,
                    output ready);
endinterface

>>> sv/mm3sm_hash_if.sv
`timescale 1ns / 1ps

interface mm3sm_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_first;
    logic [63:0] hash_second;
    logic [63:0] hash_folded;

    modport source (output valid, output hash_first, output hash_second, output hash_folded,
                    input ready);
    modport sink   (input valid, input hash_first, input hash_second, input hash_folded,
                    output ready);
endinterface

>>> sv/murmur3_style_seed_mixer_top.sv
`timescale 1ns / 1ps

// Stateless Murmur3 x64_128 style mixer: each key word pair and seed taken on the keys
// channel gives one word of two 64-bit hashes and their XOR on the hashes channel.
// A new word is taken every cycle while the first stage may load; the pipeline has 16
// stages, in which every 64-bit multiply is split into 32-bit partial products over two
// stages. When the output stalls, empty stages still fill, so input is refused only once
// all 16 stages hold a word.
`include "assert_macros.svh"

module murmur3_style_seed_mixer_top
(
    input logic          clk,
    input logic          rst_n,
    mm3sm_key_if.sink    keys,
    mm3sm_hash_if.source hashes
);

    localparam int NS = mm3sm_pkg::NUM_STAGES;

    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] en;

    // A stage may load when it is empty or when the stage after it loads too.
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || hashes.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = keys.valid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign keys.ready   = en[0];
    assign hashes.valid = vld_reg[NS-1];

    mm3sm_datapath u_datapath
    (
        .clk         (clk),
        .en          (en),
        .key_first   (keys.key_first),
        .key_second  (keys.key_second),
        .seed_word   (keys.seed_word),
        .hash_first  (hashes.hash_first),
        .hash_second (hashes.hash_second),
        .hash_folded (hashes.hash_folded)
    );

    `ASSERT_ALWAYS(a_full_when_refused, clk, rst_n, keys.ready || ((&vld_reg) && !hashes.ready), "input refused while the pipeline has a free stage")
    `ASSERT_NEXT(a_accept_enters, clk, rst_n, keys.valid && keys.ready, vld_reg[0], "accepted word did not enter the first stage")
    `ASSERT_NEXT(a_held_word_kept, clk, rst_n, vld_reg[NS-2] && !en[NS-1], vld_reg[NS-2], "word lost in a stalled stage")

endmodule

>>> sv/mm3sm_datapath.sv
`timescale 1ns / 1ps

module mm3sm_datapath
(
    input  logic                             clk,
    input  logic [mm3sm_pkg::NUM_STAGES-1:0] en,
    input  logic [63:0]                      key_first,
    input  logic [63:0]                      key_second,
    input  logic [63:0]                      seed_word,
    output logic [63:0]                      hash_first,
    output logic [63:0]                      hash_second,
    output logic [63:0]                      hash_folded
);

    typedef struct packed {
        mm3sm_pkg::pp_t pa;
        mm3sm_pkg::pp_t pb;
        logic [63:0]    seed;
    } pp2_t;

    typedef struct packed {
        logic [63:0] ka;
        logic [63:0] kb;
        logic [63:0] seed;
    } key2_t;

    typedef struct packed {
        mm3sm_pkg::pp_t pa;
        logic [63:0]    h1;
        logic [63:0]    kb;
        logic [63:0]    seed;
    } s4_t;

    typedef struct packed {
        logic [63:0] ka;
        logic [63:0] h1;
        logic [63:0] kb;
        logic [63:0] seed;
    } s5_t;

    typedef struct packed {
        mm3sm_pkg::pp_t pa;
        logic [63:0]    h1;
        logic [63:0]    h2;
    } s6_t;

    typedef struct packed {
        logic [63:0] ka;
        logic [63:0] h1;
        logic [63:0] h2;
    } s7_t;

    typedef struct packed {
        logic [63:0] h1;
        logic [63:0] h2;
    } lane2_t;

    typedef struct packed {
        mm3sm_pkg::pp_t p1;
        mm3sm_pkg::pp_t p2;
    } fin_pp_t;

    typedef struct packed {
        logic [63:0] first;
        logic [63:0] second;
        logic [63:0] folded;
    } out_t;

    pp2_t    s0_reg,  s0_next;
    key2_t   s1_reg,  s1_next;
    pp2_t    s2_reg,  s2_next;
    key2_t   s3_reg,  s3_next;
    s4_t     s4_reg,  s4_next;
    s5_t     s5_reg,  s5_next;
    s6_t     s6_reg,  s6_next;
    s7_t     s7_reg,  s7_next;
    lane2_t  s8_reg,  s8_next;
    lane2_t  s9_reg,  s9_next;
    fin_pp_t s10_reg, s10_next;
    lane2_t  s11_reg, s11_next;
    fin_pp_t s12_reg, s12_next;
    lane2_t  s13_reg, s13_next;
    lane2_t  s14_reg, s14_next;
    out_t    s15_reg, s15_next;

    always_comb
    begin
        // First scramble of both key words.
        s0_next.pa   = mm3sm_pkg::pp_mul(key_first, mm3sm_pkg::MIX_C1);
        s0_next.pb   = mm3sm_pkg::pp_mul(key_second, mm3sm_pkg::MIX_C2);
        s0_next.seed = seed_word;

        s1_next.ka   = mm3sm_pkg::pp_sum(s0_reg.pa);
        s1_next.kb   = mm3sm_pkg::pp_sum(s0_reg.pb);
        s1_next.seed = s0_reg.seed;

        s2_next.pa   = mm3sm_pkg::pp_mul(mm3sm_pkg::rotl31(s1_reg.ka), mm3sm_pkg::MIX_C2);
        s2_next.pb   = mm3sm_pkg::pp_mul(mm3sm_pkg::rotl33(s1_reg.kb), mm3sm_pkg::MIX_C1);
        s2_next.seed = s1_reg.seed;

        s3_next.ka   = mm3sm_pkg::pp_sum(s2_reg.pa);
        s3_next.kb   = mm3sm_pkg::pp_sum(s2_reg.pb);
        s3_next.seed = s2_reg.seed;

        // Lane one takes the scrambled first word while that word is scrambled again.
        s4_next.pa   = mm3sm_pkg::pp_mul(s3_reg.ka, mm3sm_pkg::MIX_C1);
        s4_next.h1   = mm3sm_pkg::rotl27(s3_reg.seed ^ s3_reg.ka) + s3_reg.seed;
        s4_next.kb   = s3_reg.kb;
        s4_next.seed = s3_reg.seed;

        s5_next.ka   = mm3sm_pkg::pp_sum(s4_reg.pa);
        s5_next.h1   = {s4_reg.h1[61:0], 2'b00} + s4_reg.h1 + mm3sm_pkg::LANE1_ADD;
        s5_next.kb   = s4_reg.kb;
        s5_next.seed = s4_reg.seed;

        s6_next.pa = mm3sm_pkg::pp_mul(mm3sm_pkg::rotl31(s5_reg.ka), mm3sm_pkg::MIX_C2);
        s6_next.h1 = s5_reg.h1;
        s6_next.h2 = mm3sm_pkg::rotl31(s5_reg.seed ^ s5_reg.kb) + s5_reg.h1;

        s7_next.ka = mm3sm_pkg::pp_sum(s6_reg.pa);
        s7_next.h1 = s6_reg.h1;
        s7_next.h2 = {s6_reg.h2[61:0], 2'b00} + s6_reg.h2 + mm3sm_pkg::LANE2_ADD;

        s8_next.h2 = s7_reg.h2 ^ mm3sm_pkg::BLOCK_LEN;
        s8_next.h1 = (s7_reg.h1 ^ s7_reg.ka ^ mm3sm_pkg::BLOCK_LEN) + s8_next.h2;

        s9_next.h1 = s8_reg.h1;
        s9_next.h2 = s8_reg.h2 + s8_reg.h1;

        // Finaliser on both lanes.
        s10_next.p1 = mm3sm_pkg::pp_mul(mm3sm_pkg::fold33(s9_reg.h1), mm3sm_pkg::FIN_D1);
        s10_next.p2 = mm3sm_pkg::pp_mul(mm3sm_pkg::fold33(s9_reg.h2), mm3sm_pkg::FIN_D1);

        s11_next.h1 = mm3sm_pkg::pp_sum(s10_reg.p1);
        s11_next.h2 = mm3sm_pkg::pp_sum(s10_reg.p2);

        s12_next.p1 = mm3sm_pkg::pp_mul(mm3sm_pkg::fold33(s11_reg.h1), mm3sm_pkg::FIN_D2);
        s12_next.p2 = mm3sm_pkg::pp_mul(mm3sm_pkg::fold33(s11_reg.h2), mm3sm_pkg::FIN_D2);

        s13_next.h1 = mm3sm_pkg::pp_sum(s12_reg.p1);
        s13_next.h2 = mm3sm_pkg::pp_sum(s12_reg.p2);

        s14_next.h2 = mm3sm_pkg::fold33(s13_reg.h2);
        s14_next.h1 = mm3sm_pkg::fold33(s13_reg.h1) + s14_next.h2;

        s15_next.first  = s14_reg.h1;
        s15_next.second = s14_reg.h2 + s14_reg.h1;
        s15_next.folded = s15_next.first ^ s15_next.second;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])  s0_reg  <= s0_next;
        if (en[1])  s1_reg  <= s1_next;
        if (en[2])  s2_reg  <= s2_next;
        if (en[3])  s3_reg  <= s3_next;
        if (en[4])  s4_reg  <= s4_next;
        if (en[5])  s5_reg  <= s5_next;
        if (en[6])  s6_reg  <= s6_next;
        if (en[7])  s7_reg  <= s7_next;
        if (en[8])  s8_reg  <= s8_next;
        if (en[9])  s9_reg  <= s9_next;
        if (en[10]) s10_reg <= s10_next;
        if (en[11]) s11_reg <= s11_next;
        if (en[12]) s12_reg <= s12_next;
        if (en[13]) s13_reg <= s13_next;
        if (en[14]) s14_reg <= s14_next;
        if (en[15]) s15_reg <= s15_next;
    end

    assign hash_first  = s15_reg.first;
    assign hash_second = s15_reg.second;
    assign hash_folded = s15_reg.folded;

endmodule

>>> tb/mm3sm_hash_checker.sv
`timescale 1ns / 1ps

module mm3sm_hash_checker
(
    input  logic        clk,
    input  logic        rst_n,
    mm3sm_key_if        keys,
    mm3sm_hash_if       hashes,
    output int unsigned mismatches,
    output int unsigned outstanding,
    output int unsigned words_checked
);

    localparam logic [63:0] KEY_MUL_A   = 64'h87c37b91114253d5;
    localparam logic [63:0] KEY_MUL_B   = 64'h4cf5ad432745937f;
    localparam logic [63:0] AVAL_MUL_A  = 64'hff51afd7ed558ccd;
    localparam logic [63:0] AVAL_MUL_B  = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] LANE_A_BIAS = 64'h0000000052dce729;
    localparam logic [63:0] LANE_B_BIAS = 64'h0000000038495ab5;
    localparam logic [63:0] BLOCK_BYTES = 64'd16;
    localparam int unsigned REPORT_MAX  = 10;

    typedef struct packed {
        logic [63:0] first;
        logic [63:0] second;
        logic [63:0] folded;
    } hash_word_t;

    hash_word_t expected_hashes[$];

    function automatic logic [63:0] rol64(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

    function automatic logic [63:0] scramble_lane_a(input logic [63:0] k);
        return rol64(k * KEY_MUL_A, 31) * KEY_MUL_B;
    endfunction

    function automatic logic [63:0] scramble_lane_b(input logic [63:0] k);
        return rol64(k * KEY_MUL_B, 33) * KEY_MUL_A;
    endfunction

    function automatic logic [63:0] avalanche(input logic [63:0] h);
        logic [63:0] x;
        x = h ^ (h >> 33);
        x = x * AVAL_MUL_A;
        x = x ^ (x >> 33);
        x = x * AVAL_MUL_B;
        return x ^ (x >> 33);
    endfunction

    function automatic hash_word_t mix_keys(input logic [63:0] key_a, input logic [63:0] key_b,
                                            input logic [63:0] seed);
        logic [63:0] ka;
        logic [63:0] kb;
        logic [63:0] h1;
        logic [63:0] h2;
        hash_word_t  w;
        h1 = seed;
        h2 = seed;
        ka = scramble_lane_a(key_a);
        h1 = rol64(h1 ^ ka, 27) + h2;
        h1 = h1 * 64'd5 + LANE_A_BIAS;
        kb = scramble_lane_b(key_b);
        h2 = rol64(h2 ^ kb, 31) + h1;
        h2 = h2 * 64'd5 + LANE_B_BIAS;
        // The scrambled first key is scrambled again and folded into lane one once more.
        ka = scramble_lane_a(ka);
        h1 = h1 ^ ka ^ BLOCK_BYTES;
        h2 = h2 ^ BLOCK_BYTES;
        h1 = h1 + h2;
        h2 = h2 + h1;
        h1 = avalanche(h1);
        h2 = avalanche(h2);
        h1 = h1 + h2;
        h2 = h2 + h1;
        w.first  = h1;
        w.second = h2;
        w.folded = h1 ^ h2;
        return w;
    endfunction

    initial
    begin
        mismatches    = 0;
        words_checked = 0;
    end

    assign outstanding = expected_hashes.size();

    always @(posedge clk)
    begin
        hash_word_t want;
        hash_word_t got;
        if (rst_n)
        begin
            if (keys.valid && keys.ready)
                expected_hashes.push_back(mix_keys(keys.key_first, keys.key_second,
                                                   keys.seed_word));
            if (hashes.valid && hashes.ready)
            begin
                got.first  = hashes.hash_first;
                got.second = hashes.hash_second;
                got.folded = hashes.hash_folded;
                if (expected_hashes.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < REPORT_MAX)
                        $display("%0t: hash word with none expected: %h %h %h", $realtime,
                                 got.first, got.second, got.folded);
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    words_checked <= words_checked + 1;
                    if (got !== want)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < REPORT_MAX)
                        begin
                            $display("%0t: hash word %0d wrong", $realtime, words_checked);
                            $display("    hash_first  expected %h got %h", want.first,
                                     got.first);
                            $display("    hash_second expected %h got %h", want.second,
                                     got.second);
                            $display("    hash_folded expected %h got %h", want.folded,
                                     got.folded);
                        end
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_murmur3_style_seed_mixer_top.sv
`timescale 1ns / 1ps

module tb_murmur3_style_seed_mixer_top;

    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned DRAIN_CYCLES  = 64;
    localparam int unsigned PHASE_WORDS   = 170;
    localparam logic [63:0] ALL_ONES      = 64'hffffffffffffffff;

    logic        clk;
    logic        rst_n;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned words_sent;
    int unsigned quiet_cycles;
    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned words_checked;

    mm3sm_key_if  keys();
    mm3sm_hash_if hashes();

    murmur3_style_seed_mixer_top DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys),
        .hashes (hashes)
    );

    mm3sm_hash_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .keys          (keys),
        .hashes        (hashes),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            hashes.ready <= 1'b0;
        else
            hashes.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((keys.valid && keys.ready) || (hashes.valid && hashes.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [63:0] pick_word();
        logic [63:0] w;
        case ($urandom_range(9))
            0:       w = 64'd0;
            1:       w = ALL_ONES;
            2:       w = 64'd1 << $urandom_range(63);
            3:       w = ~(64'd1 << $urandom_range(63));
            4:       w = 64'($urandom_range(255));
            default: w = {$urandom(), $urandom()};
        endcase
        return w;
    endfunction

    // Holds the word on the channel until it is taken, after a random number of idle cycles.
    task automatic send_word(input logic [63:0] ka, input logic [63:0] kb,
                             input logic [63:0] seed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            keys.valid <= 1'b0;
            @(posedge clk);
        end
        keys.valid      <= 1'b1;
        keys.key_first  <= ka;
        keys.key_second <= kb;
        keys.seed_word  <= seed;
        @(posedge clk);
        while (!keys.ready)
            @(posedge clk);
        words_sent++;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        words_sent      = 0;
        quiet_cycles    = 0;
        keys.valid      = 1'b0;
        keys.key_first  = 64'd0;
        keys.key_second = 64'd0;
        keys.seed_word  = 64'd0;
        hashes.ready    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, single bits and alternating patterns, back to back.
        send_word(64'd0, 64'd0, 64'd0);
        send_word(ALL_ONES, ALL_ONES, ALL_ONES);
        send_word(ALL_ONES, 64'd0, 64'd0);
        send_word(64'd0, ALL_ONES, 64'd0);
        send_word(64'd0, 64'd0, ALL_ONES);
        send_word(64'd1, 64'd0, 64'd0);
        send_word(64'd0, 64'd1, 64'd0);
        send_word(64'd0, 64'd0, 64'd1);
        send_word(64'h8000000000000000, 64'h8000000000000000, 64'h8000000000000000);
        send_word(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_word(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        send_word(64'h00000000ffffffff, 64'hffffffff00000000, 64'h00000000ffffffff);
        send_word(64'hffffffff00000000, 64'h00000000ffffffff, 64'hffffffff00000000);
        send_word(64'h0000000065f3a1c2, 64'h000000003b9ac9ff, 64'h0123456789abcdef);
        send_word(64'hfedcba9876543210, 64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0);
        // A repeat of an earlier word must hash the same, as the block holds no state.
        send_word(64'd0, 64'd0, 64'd0);
        send_word(ALL_ONES, ALL_ONES, ALL_ONES);
        send_word(64'h7fffffffffffffff, 64'h7fffffffffffffff, 64'h7fffffffffffffff);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            endcase
            repeat (PHASE_WORDS)
                send_word(pick_word(), pick_word(), pick_word());
            if (phase == 1)
            begin
                // Let the pipeline empty completely before carrying on.
                keys.valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
        end

        keys.valid    <= 1'b0;
        recv_stall_pct = 0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d key words, %0d directed, the rest random over four idle and stall mixes.",
                 words_sent, 18);
        $display("Checked %0d hash words, %0d wrong, %0d still awaited.",
                 words_checked, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
